/* src/assert_macros.svh */
// Assertion macros used by the checker file of this block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock edge, disabled while reset is high
`define CHK_ASSERT_RST(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent check on the rising clock edge, held during reset too
`define CHK_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/ctb_pkg.sv */
// Package: operation codes and shared types of the countdown timer bank
`timescale 1ns / 1ps
`default_nettype none
package ctb_pkg;

  // Operation codes carried in func
  localparam logic [2:0] FN_SET     = 3'd0;
  localparam logic [2:0] FN_STOP    = 3'd1;
  localparam logic [2:0] FN_GET     = 3'd2;
  localparam logic [2:0] FN_QUERY   = 3'd3;
  localparam logic [2:0] FN_EXPIRED = 3'd4;
  localparam logic [2:0] FN_IOE     = 3'd5;

  // Status of the update sweep toward the controller
  typedef struct packed {
    logic walking;   // read addresses are issued by the sweep
    logic finished;  // last write-back happens in this cycle
  } sweep_stat_t;

endpackage
`default_nettype wire

/* src/ctb_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data
`timescale 1ns / 1ps
`default_nettype none
module ctb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* src/ctb_sweep.sv */
// Update sweep: walks every timer entry, subtracts elapsed ticks, writes back
`timescale 1ns / 1ps
`default_nettype none
module ctb_sweep #(
  parameter int NUM_TIMERS = 16,
  parameter int TICK_BITS  = 32,
  parameter int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      go,
  input  logic [TICK_BITS-1:0]      diff,
  input  logic [NUM_TIMERS-1:0]     act,
  input  logic [TICK_BITS-1:0]      rd_data,
  output logic [IDX_W-1:0]          rd_addr,
  output logic                      wr_en,
  output logic [IDX_W-1:0]          wr_addr,
  output logic [TICK_BITS-1:0]      wr_data,
  output ctb_pkg::sweep_stat_t      stat
);
  import ctb_pkg::*;

  logic                 walking;
  logic                 pend;
  logic [IDX_W-1:0]     k;
  logic [IDX_W-1:0]     wr_k;
  logic [TICK_BITS-1:0] diff_r;

  // Walk control: one read issued per cycle, write-back in the following cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      walking <= 1'b0;
      pend    <= 1'b0;
      k       <= '0;
    end else begin
      pend <= walking;
      if (go) begin
        walking <= 1'b1;
        k       <= '0;
      end else if (walking) begin
        k <= k + 1'b1;
        if (k == IDX_W'(NUM_TIMERS - 1)) begin
          walking <= 1'b0;
        end
      end
    end
  end

  // Hold the elapsed count and the entry under write-back
  always_ff @(posedge clk) begin
    if (go) begin
      diff_r <= diff;
    end
    wr_k <= k;
  end

  // Saturating subtract on active entries only
  always_comb begin
    rd_addr = k;
    wr_addr = wr_k;
    wr_en   = pend && act[wr_k];
    wr_data = (rd_data > diff_r) ? (rd_data - diff_r) : '0;
    stat.walking  = walking;
    stat.finished = pend && !walking;
  end

endmodule
`default_nettype wire

/* src/countdown_timer_bank_unit.sv */
// Top level of the countdown timer bank: request control, flags and result
//
//   channel   signals                                   transfer when
//   request   start, func, timer_index, duration,       start && !busy
//             tick_count
//   result    done, ok, remaining                       done (one cycle)
//
// A request that needs an update and sees elapsed ticks runs the sweep state
// between the check and read states; all others go from check to read.
// The update walks the tick memory once, one entry per cycle over its single
// read port, with the write-back of each entry in the cycle after its read.
// Reset clears the active flags and the last tick seen; an inactive entry
// reads as zero, so the tick memory needs no clearing pass.
// busy is high from the cycle after accept until done; done cannot be held off.
`timescale 1ns / 1ps
`default_nettype none
module countdown_timer_bank_unit #(
  parameter int NUM_TIMERS = 16,
  parameter int TICK_BITS  = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  func,
  input  logic [7:0]  timer_index,
  input  logic [31:0] duration,
  input  logic [31:0] tick_count,
  output logic        done,
  output logic        ok,
  output logic [31:0] remaining
);
  import ctb_pkg::*;

  localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_SWEEP = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]            state;
  logic [2:0]            func_r;
  logic                  idx_ok;
  logic [IDX_W-1:0]      t_r;
  logic [TICK_BITS-1:0]  dur_r;
  logic [TICK_BITS-1:0]  now_r;
  logic [TICK_BITS-1:0]  seen_tick;
  logic [NUM_TIMERS-1:0] act;

  logic [TICK_BITS-1:0]  diff;
  logic                  act_t;
  logic                  need_upd;
  logic                  sweep_go;
  logic [TICK_BITS-1:0]  cur;
  logic                  ok_next;
  logic [31:0]           rem_next;
  logic                  act_set;
  logic                  act_clr;

  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  logic [TICK_BITS-1:0]  ram_wdata;
  logic [IDX_W-1:0]      ram_raddr;
  logic [TICK_BITS-1:0]  ram_rdata;

  logic                  sw_we;
  logic [IDX_W-1:0]      sw_waddr;
  logic [TICK_BITS-1:0]  sw_wdata;
  logic [IDX_W-1:0]      sw_raddr;
  sweep_stat_t           sw_stat;

  assign busy = (state != S_IDLE);

  // Decode the request against the current flags and tick memory output
  always_comb begin
    diff     = now_r - seen_tick;
    act_t    = act[t_r];
    cur      = act_t ? ram_rdata : '0;
    need_upd = 1'b0;
    ok_next  = 1'b0;
    rem_next = '0;
    act_set  = 1'b0;
    act_clr  = 1'b0;
    if (idx_ok) begin
      case (func_r)
        FN_SET: begin
          need_upd = 1'b1;
          ok_next  = 1'b1;
          act_set  = 1'b1;
        end
        FN_STOP: begin
          ok_next = 1'b1;
          act_clr = 1'b1;
        end
        FN_GET: begin
          need_upd = act_t;
          rem_next = 32'(cur);
        end
        FN_QUERY: begin
          ok_next = act_t;
        end
        FN_EXPIRED: begin
          need_upd = act_t;
          if (act_t && (ram_rdata == '0)) begin
            act_clr = 1'b1;
            ok_next = 1'b1;
          end
        end
        FN_IOE: begin
          need_upd = 1'b1;
          act_clr  = (cur == '0);
          ok_next  = (cur == '0);
        end
        default: begin
          need_upd = 1'b0;
        end
      endcase
    end
    sweep_go = (state == S_CHECK) && need_upd && (diff != '0);
  end

  // Memory port selection: sweep owns the ports while it runs
  always_comb begin
    ram_we    = sw_we || ((state == S_DONE) && act_set);
    ram_waddr = sw_we ? sw_waddr : t_r;
    ram_wdata = sw_we ? sw_wdata : dur_r;
    ram_raddr = sw_stat.walking ? sw_raddr : t_r;
  end

  // Request sequencer, flags and last tick seen
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      done      <= 1'b0;
      act       <= '0;
      seen_tick <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (sweep_go) begin
            seen_tick <= now_r;
            state     <= S_SWEEP;
          end else begin
            state <= S_READ;
          end
        end
        S_SWEEP: begin
          if (sw_stat.finished) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_DONE;
        end
        S_DONE: begin
          done  <= 1'b1;
          state <= S_IDLE;
          if (act_set) begin
            act[t_r] <= 1'b1;
          end else if (act_clr) begin
            act[t_r] <= 1'b0;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Capture the request and the result payload
  always_ff @(posedge clk) begin
    if ((state == S_IDLE) && start) begin
      func_r <= func;
      idx_ok <= (timer_index < 8'(NUM_TIMERS));
      t_r    <= (timer_index < 8'(NUM_TIMERS)) ? timer_index[IDX_W-1:0] : '0;
      dur_r  <= TICK_BITS'(duration);
      now_r  <= TICK_BITS'(tick_count);
    end
    if (state == S_DONE) begin
      ok        <= ok_next;
      remaining <= rem_next;
    end
  end

  ctb_sweep #(
    .NUM_TIMERS (NUM_TIMERS),
    .TICK_BITS  (TICK_BITS)
  ) u_sweep (
    .clk     (clk),
    .rst     (rst),
    .go      (sweep_go),
    .diff    (diff),
    .act     (act),
    .rd_data (ram_rdata),
    .rd_addr (sw_raddr),
    .wr_en   (sw_we),
    .wr_addr (sw_waddr),
    .wr_data (sw_wdata),
    .stat    (sw_stat)
  );

  ctb_ram #(
    .WIDTH (TICK_BITS),
    .DEPTH (NUM_TIMERS)
  ) u_ticks (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule
`default_nettype wire

/* src/ctb_checker.sv */
// Port-level checks of the countdown timer bank and their bind
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module ctb_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic        ok,
  input logic [31:0] remaining
);

  // An accepted request keeps the block busy in the next cycle
  `CHK_ASSERT_RST(a_accept_busy, clk, rst, (start && !busy) |=> busy, "accept without busy")

  // A result never shows while a request is still in work
  `CHK_ASSERT_ALWAYS(a_done_idle, clk, done |-> !busy, "result while busy")

  // One result per request: the strobe lasts a single cycle
  `CHK_ASSERT_RST(a_done_pulse, clk, rst, done |=> !done, "result strobe repeated")

  // busy drops only together with the result
  `CHK_ASSERT_RST(a_busy_end, clk, rst, ($fell(busy) && !$past(rst)) |-> done, "busy fell w/o result")

  // A nonzero remaining count comes with ok low
  `CHK_ASSERT_RST(a_rem_ok, clk, rst, (done && (remaining != 32'd0)) |-> !ok, "remaining with ok")

endmodule

bind countdown_timer_bank_unit ctb_checker u_chk (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .done      (done),
  .ok        (ok),
  .remaining (remaining)
);
`default_nettype wire
